// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files; the top level uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// Check that cond implies prop in the cycle after.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/ibr_pkg.sv -----
// Types and constants of the I2C bus recovery sequencer.
package ibr_pkg;

	localparam int unsigned HALF_W  = 16;
	localparam int unsigned PULSE_W = 4;
	localparam int unsigned RETRY_W = 10;
	localparam int unsigned TIMER_W = 17;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TOTAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH     = 2'd2;

	localparam logic [HALF_W-1:0]  HALF_RST    = 16'd7;
	localparam logic [PULSE_W-1:0] PULSE_RST   = 4'd9;
	localparam logic [RETRY_W-1:0] STRETCH_RST = 10'd250;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SCL_LOW = 2'd1,
		ST_SDA_LOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [HALF_W-1:0]  half_period_ticks;
		logic [PULSE_W-1:0] pulse_total;
		logic [RETRY_W-1:0] stretch_retries;
	} cfg_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic idle;
	} fsm_stat_t;

endpackage

// ----- hw/rtl/ibr_in_if.sv -----
// Input channel: one tick with start request and sampled line levels.
interface ibr_in_if;
	logic valid;
	logic ready;
	logic start_req;
	logic scl_level;
	logic sda_level;

	modport source (output valid, output start_req, output scl_level, output sda_level,
		input ready);
	modport sink (input valid, input start_req, input scl_level, input sda_level,
		output ready);
endinterface

// ----- hw/rtl/ibr_out_if.sv -----
// Result channel: line drives, busy, done and last status.
interface ibr_out_if;
	logic       valid;
	logic       ready;
	logic       scl_drive_low;
	logic       sda_drive_low;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, output scl_drive_low, output sda_drive_low,
		output busy_res, output done_res, output status, input ready);
	modport sink (input valid, input scl_drive_low, input sda_drive_low,
		input busy_res, input done_res, input status, output ready);
endinterface

// ----- hw/rtl/ibr_cfg_regs.sv -----
// Configuration registers of the bus recovery sequencer.
module ibr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ibr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ibr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ibr_pkg::cfg_t                  cfg
);
	import ibr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_RST;
			cfg_q.pulse_total       <= PULSE_RST;
			cfg_q.stretch_retries   <= STRETCH_RST;
		end else if (cfg_we) begin
			// indexes beyond the list fall through and are dropped
			unique case (cfg_index)
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_wdata[HALF_W-1:0];
				REG_PULSE_TOTAL: cfg_q.pulse_total       <= cfg_wdata[PULSE_W-1:0];
				REG_STRETCH:     cfg_q.stretch_retries   <= cfg_wdata[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- hw/rtl/ibr_seq_fsm.sv -----
// Recovery state machine: one tick per accepted transaction.
module ibr_seq_fsm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               start_req,
	input  logic               scl_level,
	input  logic               sda_level,
	input  ibr_pkg::cfg_t      cfg,
	output ibr_pkg::res_t      res,
	output ibr_pkg::fsm_stat_t stat
);
	import ibr_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_SETTLE    = 3'd1,
		PH_LOW       = 3'd2,
		PH_HIGH      = 3'd3,
		PH_STRETCH   = 3'd4,
		PH_PRESTART  = 3'd5,
		PH_START_LOW = 3'd6
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [PULSE_W-1:0] pulses_q, pulses_d;
	logic [TIMER_W-1:0] timer_q, timer_d;
	logic [RETRY_W-1:0] retries_q, retries_d;
	logic [1:0]         status_q, status_d;
	logic               done;

	logic [TIMER_W-1:0] half_len;
	logic [TIMER_W-1:0] full_len;
	logic [TIMER_W-1:0] timer_dec;
	logic               wait_over;
	logic [PULSE_W-1:0] pulses_inc;
	logic [RETRY_W-1:0] retries_dec;

	assign half_len   = (cfg.half_period_ticks == '0) ? TIMER_W'(1)
		: {1'b0, cfg.half_period_ticks};
	assign full_len   = {half_len[TIMER_W-2:0], 1'b0};
	assign timer_dec  = (timer_q != '0) ? timer_q - TIMER_W'(1) : '0;
	assign wait_over  = (timer_dec == '0);
	assign pulses_inc = pulses_q + PULSE_W'(1);
	assign retries_dec = (retries_q != '0) ? retries_q - RETRY_W'(1) : '0;

	always_comb begin
		phase_d   = phase_q;
		pulses_d  = pulses_q;
		timer_d   = timer_q;
		retries_d = retries_q;
		status_d  = status_q;
		done      = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d  = PH_SETTLE;
					timer_d  = half_len;
					pulses_d = '0;
				end
			end
			PH_SETTLE: begin
				timer_d = timer_dec;
				if (wait_over) begin
					if (!scl_level) begin
						status_d = ST_SCL_LOW;
						phase_d  = PH_IDLE;
						timer_d  = '0;
						done     = 1'b1;
					end else begin
						pulses_d = '0;
						phase_d  = PH_LOW;
						timer_d  = half_len;
					end
				end
			end
			PH_LOW: begin
				timer_d = timer_dec;
				if (wait_over) begin
					phase_d = PH_HIGH;
					timer_d = half_len;
				end
			end
			PH_HIGH, PH_STRETCH: begin
				timer_d = timer_dec;
				if (wait_over) begin
					if (phase_q == PH_STRETCH) begin
						retries_d = retries_dec;
					end
					if (scl_level) begin
						// pulse seen high: next pulse, SDA check or START
						pulses_d = pulses_inc;
						if (pulses_inc < cfg.pulse_total) begin
							phase_d = PH_LOW;
							timer_d = half_len;
						end else if (!sda_level) begin
							status_d = ST_SDA_LOW;
							phase_d  = PH_IDLE;
							timer_d  = '0;
							done     = 1'b1;
						end else begin
							phase_d = PH_PRESTART;
							timer_d = half_len;
						end
					end else if ((phase_q == PH_HIGH && cfg.stretch_retries == '0)
							|| (phase_q == PH_STRETCH && retries_dec == '0)) begin
						status_d = ST_SCL_LOW;
						phase_d  = PH_IDLE;
						timer_d  = '0;
						done     = 1'b1;
					end else begin
						if (phase_q == PH_HIGH) begin
							retries_d = cfg.stretch_retries;
						end
						phase_d = PH_STRETCH;
						timer_d = full_len;
					end
				end
			end
			PH_PRESTART: begin
				timer_d = timer_dec;
				if (wait_over) begin
					phase_d = PH_START_LOW;
					timer_d = half_len;
				end
			end
			PH_START_LOW: begin
				timer_d = timer_dec;
				if (wait_over) begin
					status_d = ST_OK;
					phase_d  = PH_IDLE;
					timer_d  = '0;
					done     = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				timer_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pulses_q  <= '0;
			timer_q   <= '0;
			retries_q <= '0;
			status_q  <= ST_OK;
		end else if (step) begin
			phase_q   <= phase_d;
			pulses_q  <= pulses_d;
			timer_q   <= timer_d;
			retries_q <= retries_d;
			status_q  <= status_d;
		end
	end

	assign res.scl_drive_low = (phase_d == PH_LOW);
	assign res.sda_drive_low = (phase_d == PH_START_LOW);
	assign res.busy_res      = (phase_d != PH_IDLE);
	assign res.done_res      = done;
	assign res.status        = status_d;

	assign stat.idle = (phase_q == PH_IDLE);
endmodule

// ----- hw/rtl/ibr_out_reg.sv -----
// Result register between the state machine and the result channel.
module ibr_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ibr_pkg::res_t res,
	output logic          space,
	ibr_out_if.source     results
);
	import ibr_pkg::*;

	logic valid_q;
	res_t res_q;

	// take a new result when empty or when the held one leaves this cycle
	assign space = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign results.valid         = valid_q;
	assign results.scl_drive_low = res_q.scl_drive_low;
	assign results.sda_drive_low = res_q.sda_drive_low;
	assign results.busy_res      = res_q.busy_res;
	assign results.done_res      = res_q.done_res;
	assign results.status        = res_q.status;
endmodule

// ----- hw/rtl/i2c_bus_recovery_sequencer.sv -----
// Top level of the I2C bus recovery sequencer.
//
//   channel   direction  payload
//   ticks     in         start_req, scl_level, sda_level
//   results   out        scl_drive_low, sda_drive_low, busy_res, done_res, status
//   cfg_*     in         write enable, register index, write data
//
// One transaction per cycle while ticks.ready is high; each tick gives its result in the cycle after acceptance.
// The state machine advances only on an accepted tick; the result register
// holds a finished result until results.ready and loads the next one as it leaves.
// ticks.ready falls only while the result register is full and results.ready is low.
// Reset clears the state machine to idle and loads the default configuration.
`include "assert_macros.svh"

module i2c_bus_recovery_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	ibr_in_if.sink                         ticks,
	ibr_out_if.source                      results,
	input  logic                           cfg_we,
	input  logic [ibr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ibr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ibr_pkg::*;

	cfg_t      cfg;
	res_t      res;
	fsm_stat_t stat;
	logic      space;
	logic      step;

	assign ticks.ready = space;
	assign step        = ticks.valid && space;

	ibr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ibr_seq_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.start_req (ticks.start_req),
		.scl_level (ticks.scl_level),
		.sda_level (ticks.sda_level),
		.cfg       (cfg),
		.res       (res),
		.stat      (stat)
	);

	ibr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step),
		.res     (res),
		.space   (space),
		.results (results)
	);

	`ASSERT_SAME(a_done_not_busy, clk, arst_n, results.valid && results.done_res,
		!results.busy_res)
	`ASSERT_SAME(a_one_line_driven, clk, arst_n, results.valid,
		!(results.scl_drive_low && results.sda_drive_low))
	`ASSERT_NEXT(a_start_goes_busy, clk, arst_n, step && stat.idle && ticks.start_req,
		results.valid && results.busy_res && !results.done_res)
	`ASSERT_NEXT(a_idle_holds_status, clk, arst_n, step && stat.idle,
		results.valid && !results.done_res)
endmodule
